// ----- rtl/core/hcc_pkg.sv -----
// shared types, widths and codes of the homography corner check
package hcc_pkg;

   localparam int COEF_W          = 40;
   localparam int COORD_FRAC_BITS = 8;
   localparam int PIX_W           = 13;
   localparam int COORD_W         = PIX_W + COORD_FRAC_BITS;
   localparam int PROD_W          = COEF_W + PIX_W + 1;
   localparam int SUM_W           = PROD_W + 2;
   localparam int DIV_STEPS       = COORD_W;
   localparam int DIV_W           = SUM_W + COORD_W - 1;
   localparam int REM_W           = SUM_W + COORD_W;
   localparam int DIV_CNT_W       = $clog2(DIV_STEPS + 1);
   localparam int SQ_W            = 2 * COORD_W + 2;
   localparam int SQRT_W          = COORD_W + 1;
   localparam int SQ_CYCLES       = (COORD_W + 2) / 2;
   localparam int SQ_CNT_W        = $clog2(SQ_CYCLES + 1);
   localparam int DSUM_W          = COORD_W + 3;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_LEFT        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_TOP         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEVIATION_LIMIT = 3'd4;

   localparam logic [1:0] CORNER_TL = 2'd0;
   localparam logic [1:0] CORNER_BR = 2'd3;

   typedef enum logic [1:0] {
      CLS_ZERO   = 2'd0,
      CLS_LIMIT  = 2'd1,
      CLS_DIVIDE = 2'd2
   } cls_type;

   typedef struct packed {
      logic [11:0] frame_width;
      logic [11:0] frame_height;
      logic [9:0]  pad_left;
      logic [9:0]  pad_top;
      logic [23:0] deviation_limit;
   } cfg_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_r0c0;
      logic signed [COEF_W-1:0] coef_r0c1;
      logic signed [COEF_W-1:0] coef_r0c2;
      logic signed [COEF_W-1:0] coef_r1c0;
      logic signed [COEF_W-1:0] coef_r1c1;
      logic signed [COEF_W-1:0] coef_r1c2;
      logic signed [COEF_W-1:0] coef_r2c0;
      logic signed [COEF_W-1:0] coef_r2c1;
      logic signed [COEF_W-1:0] coef_r2c2;
   } req_type;

   typedef struct packed {
      logic [1:0]         corner_index;
      logic [COORD_W-1:0] corner_x;
      logic [COORD_W-1:0] corner_y;
      logic               last_corner;
      logic [PIX_W-1:0]   box_left;
      logic [PIX_W-1:0]   box_top;
      logic [PIX_W-1:0]   box_width;
      logic [PIX_W-1:0]   box_height;
      logic               skip_frame;
   } rsp_type;

   typedef struct packed {
      logic [1:0]       corner;
      logic [PIX_W-1:0] px;
      logic [PIX_W-1:0] py;
      cls_type          cls_x;
      cls_type          cls_y;
      logic [SUM_W-1:0] mag_nx;
      logic [SUM_W-1:0] mag_ny;
      logic [SUM_W-1:0] mag_d;
   } job_type;

endpackage

// ----- rtl/core/hcc_front.sv -----
// front end: takes a homography, forms per-corner numerators and divisor, classifies them
module hcc_front import hcc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   input  logic    job_full,
   output logic    job_push,
   output job_type job
);

   logic                     busy_ff, busy_in;
   req_type                  coef_ff, coef_in;
   logic [1:0]               corner_ff, corner_in;
   logic                     p_valid_ff, p_valid_in;
   logic [1:0]               p_corner_ff;
   logic [PIX_W-1:0]         p_px_ff, p_py_ff;
   logic signed [PROD_W-1:0] prod_ff [6];
   logic signed [PROD_W-1:0] prod_in [6];
   logic signed [COEF_W-1:0] off_ff [3];
   logic                     s_valid_ff, s_valid_in;
   logic [1:0]               s_corner_ff;
   logic [PIX_W-1:0]         s_px_ff, s_py_ff;
   logic signed [SUM_W-1:0]  nx_ff, ny_ff, d_ff;
   logic signed [SUM_W-1:0]  nx_in, ny_in, d_in;
   logic [PIX_W-1:0]         x_pos, y_pos;
   logic                     accept, s_move, s_free, p_move, p_free, issue;

   function automatic cls_type classify(input logic signed [SUM_W-1:0] num,
                                        input logic signed [SUM_W-1:0] den);
      cls_type c;
      if (den == '0) begin
         c = (!num[SUM_W-1] && num != '0) ? CLS_LIMIT : CLS_ZERO;
      end else if (num == '0 || num[SUM_W-1] != den[SUM_W-1]) begin
         c = CLS_ZERO;
      end else begin
         c = CLS_DIVIDE;
      end
      return c;
   endfunction

   function automatic logic [SUM_W-1:0] magnitude(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-1:0] u;
      u = v;
      return v[SUM_W-1] ? (SUM_W'(0) - u) : u;
   endfunction

   assign full     = busy_ff;
   assign accept   = push & ~busy_ff;
   assign s_move   = s_valid_ff & ~job_full;
   assign s_free   = ~s_valid_ff | s_move;
   assign p_move   = p_valid_ff & s_free;
   assign p_free   = ~p_valid_ff | p_move;
   assign issue    = busy_ff & p_free;
   assign job_push = s_move;

   always_comb begin
      x_pos = corner_ff[1] ? PIX_W'(cfg.pad_left) + PIX_W'(cfg.frame_width)
                           : PIX_W'(cfg.pad_left);
      y_pos = corner_ff[0] ? PIX_W'(cfg.pad_top) + PIX_W'(cfg.frame_height)
                           : PIX_W'(cfg.pad_top);
      prod_in[0] = coef_ff.coef_r0c0 * $signed({1'b0, x_pos});
      prod_in[1] = coef_ff.coef_r0c1 * $signed({1'b0, y_pos});
      prod_in[2] = coef_ff.coef_r1c0 * $signed({1'b0, x_pos});
      prod_in[3] = coef_ff.coef_r1c1 * $signed({1'b0, y_pos});
      prod_in[4] = coef_ff.coef_r2c0 * $signed({1'b0, x_pos});
      prod_in[5] = coef_ff.coef_r2c1 * $signed({1'b0, y_pos});
      nx_in = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_W'(off_ff[0]);
      ny_in = SUM_W'(prod_ff[2]) + SUM_W'(prod_ff[3]) + SUM_W'(off_ff[1]);
      d_in  = SUM_W'(prod_ff[4]) + SUM_W'(prod_ff[5]) + SUM_W'(off_ff[2]);
   end

   always_comb begin
      busy_in    = busy_ff;
      corner_in  = corner_ff;
      coef_in    = coef_ff;
      p_valid_in = p_valid_ff;
      s_valid_in = s_valid_ff;
      if (accept) begin
         busy_in   = 1'b1;
         corner_in = CORNER_TL;
         coef_in   = req_data;
      end else if (issue) begin
         corner_in = corner_ff + 2'd1;
         if (corner_ff == CORNER_BR) begin
            busy_in = 1'b0;
         end
      end
      if (issue) begin
         p_valid_in = 1'b1;
      end else if (p_move) begin
         p_valid_in = 1'b0;
      end
      if (p_move) begin
         s_valid_in = 1'b1;
      end else if (s_move) begin
         s_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         corner_ff  <= CORNER_TL;
         p_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         corner_ff  <= corner_in;
         p_valid_ff <= p_valid_in;
         s_valid_ff <= s_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      coef_ff <= coef_in;
      if (issue) begin
         p_corner_ff <= corner_ff;
         p_px_ff     <= x_pos;
         p_py_ff     <= y_pos;
         for (int i = 0; i < 6; i++) begin
            prod_ff[i] <= prod_in[i];
         end
         off_ff[0] <= coef_ff.coef_r0c2;
         off_ff[1] <= coef_ff.coef_r1c2;
         off_ff[2] <= coef_ff.coef_r2c2;
      end
      if (p_move) begin
         s_corner_ff <= p_corner_ff;
         s_px_ff     <= p_px_ff;
         s_py_ff     <= p_py_ff;
         nx_ff       <= nx_in;
         ny_ff       <= ny_in;
         d_ff        <= d_in;
      end
   end

   always_comb begin
      job.corner = s_corner_ff;
      job.px     = s_px_ff;
      job.py     = s_py_ff;
      job.cls_x  = classify(nx_ff, d_ff);
      job.cls_y  = classify(ny_ff, d_ff);
      job.mag_nx = magnitude(nx_ff);
      job.mag_ny = magnitude(ny_ff);
      job.mag_d  = magnitude(d_ff);
   end

endmodule

// ----- rtl/core/hcc_job_queue.sv -----
// two-entry queue of corner jobs between front and back
module hcc_job_queue import hcc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type pop_data
);

   job_type    mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push & ~do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop & ~do_push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/core/hcc_divider.sv -----
// restoring divider, one quotient bit a cycle, with clamp to the coordinate limit
module hcc_divider import hcc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               ack,
   input  cls_type            cls,
   input  logic [SUM_W-1:0]   num,
   input  logic [SUM_W-1:0]   den,
   input  logic [COORD_W-1:0] lim,
   output logic               idle,
   output logic               done,
   output logic [COORD_W-1:0] quo
);

   logic                 run_ff, run_in, done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     dvs_ff, dvs_in;
   logic [COORD_W-1:0]   q_ff, q_in, lim_ff, lim_in;
   logic                 sat_ff, sat_in, zero_ff, zero_in;
   logic                 ge;

   assign ge   = rem_ff >= REM_W'(dvs_ff);
   assign idle = ~run_ff & ~done_ff;
   assign done = done_ff;
   assign quo  = zero_ff ? '0 : ((sat_ff || q_ff > lim_ff) ? lim_ff : q_ff);

   always_comb begin
      run_in  = run_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      q_in    = q_ff;
      lim_in  = lim_ff;
      sat_in  = sat_ff;
      zero_in = zero_ff;
      if (start) begin
         run_in  = 1'b1;
         done_in = 1'b0;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         rem_in  = REM_W'(num) << COORD_FRAC_BITS;
         dvs_in  = DIV_W'(den) << (COORD_W - 1);
         q_in    = '0;
         lim_in  = lim;
         zero_in = cls == CLS_ZERO;
         // quotient would need more bits than the limit has: saturate
         sat_in  = (cls == CLS_LIMIT) ||
                   (cls == CLS_DIVIDE &&
                    (REM_W'(num) << COORD_FRAC_BITS) >= (REM_W'(den) << COORD_W));
      end else if (run_ff) begin
         rem_in = ge ? rem_ff - REM_W'(dvs_ff) : rem_ff;
         q_in   = {q_ff[COORD_W-2:0], ge};
         dvs_in = dvs_ff >> 1;
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end else if (ack) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      q_ff    <= q_in;
      lim_ff  <= lim_in;
      sat_ff  <= sat_in;
      zero_ff <= zero_in;
   end

endmodule

// ----- rtl/core/hcc_sqrt.sv -----
// floor square root of dx*dx+dy*dy, two result bits a cycle
module hcc_sqrt import hcc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [COORD_W-1:0] dx,
   input  logic [COORD_W-1:0] dy,
   output logic               done,
   output logic [SQRT_W-1:0]  root
);

   typedef struct packed {
      logic [SQ_W-1:0] v;
      logic [SQ_W-1:0] res;
      logic [SQ_W-1:0] b;
   } sq_state_type;

   logic                  run_ff, run_in, done_ff, done_in;
   logic [SQ_CNT_W-1:0]   cnt_ff, cnt_in;
   sq_state_type          st_ff, st_in, st_mid, st_two;
   logic [2*COORD_W-1:0]  dx_sq, dy_sq;

   function automatic sq_state_type sq_step(input sq_state_type s);
      sq_state_type o;
      o = s;
      if (s.v >= s.res + s.b) begin
         o.v   = s.v - (s.res + s.b);
         o.res = (s.res >> 1) + s.b;
      end else begin
         o.res = s.res >> 1;
      end
      o.b = s.b >> 2;
      return o;
   endfunction

   assign done  = done_ff;
   assign root  = st_ff.res[SQRT_W-1:0];
   assign dx_sq = dx * dx;
   assign dy_sq = dy * dy;

   always_comb begin
      st_mid  = sq_step(st_ff);
      st_two  = sq_step(st_mid);
      run_in  = run_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      st_in   = st_ff;
      if (start) begin
         run_in    = 1'b1;
         done_in   = 1'b0;
         cnt_in    = SQ_CNT_W'(SQ_CYCLES);
         st_in.v   = SQ_W'(dx_sq) + SQ_W'(dy_sq);
         st_in.res = '0;
         st_in.b   = SQ_W'(1) << (2 * COORD_W);
      end else if (run_ff) begin
         st_in  = st_two;
         cnt_in = cnt_ff - SQ_CNT_W'(1);
         if (cnt_ff == SQ_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
   end

endmodule

// ----- rtl/core/hcc_back.sv -----
// back end: divides, measures deviation, builds box and queues results
module hcc_back import hcc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    job_empty,
   input  job_type job,
   output logic    job_pop,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic [PIX_W-1:0]   pad_x, pad_y, right_x, bottom_y, span_x, span_y;
   logic [COORD_W-1:0] lim_x, lim_y;
   logic               idle_x, idle_y, done_x, done_y;
   logic [COORD_W-1:0] quo_x, quo_y;
   logic               div_start, cs_load, cs_push;
   logic [1:0]         dj_corner_ff;
   logic [PIX_W-1:0]   dj_px_ff, dj_py_ff;
   logic               cs_valid_ff, cs_valid_in, cs_start_ff;
   logic [1:0]         cs_corner_ff;
   logic [COORD_W-1:0] cs_cx_ff, cs_cy_ff, cs_dx_ff, cs_dy_ff;
   logic [COORD_W-1:0] ref_x, ref_y, dx_in, dy_in;
   logic               sq_done;
   logic [SQRT_W-1:0]  sq_root;
   logic [PIX_W-1:0]   minx_ff, miny_ff, maxx_ff, maxy_ff;
   logic [PIX_W-1:0]   minx_in, miny_in, maxx_in, maxy_in, ix, iy, bl, bt, rx, by;
   logic [DSUM_W-1:0]  dsum_ff, dsum_in;
   logic               first, last;
   rsp_type            rsp_in;
   rsp_type            oq_ff [2];
   logic               wr_ptr_ff, rd_ptr_ff;
   logic [1:0]         oq_cnt_ff, oq_cnt_in;
   logic               oq_full, oq_pop;

   assign pad_x    = PIX_W'(cfg.pad_left);
   assign pad_y    = PIX_W'(cfg.pad_top);
   assign right_x  = pad_x + PIX_W'(cfg.frame_width);
   assign bottom_y = pad_y + PIX_W'(cfg.frame_height);
   assign span_x   = PIX_W'({cfg.pad_left, 1'b0}) + PIX_W'(cfg.frame_width);
   assign span_y   = PIX_W'({cfg.pad_top, 1'b0}) + PIX_W'(cfg.frame_height);
   assign lim_x    = {span_x, COORD_FRAC_BITS'(0)};
   assign lim_y    = {span_y, COORD_FRAC_BITS'(0)};

   assign div_start = ~job_empty & idle_x & idle_y;
   assign job_pop   = div_start;
   assign cs_load   = done_x & done_y & ~cs_valid_ff;
   assign oq_full   = oq_cnt_ff == 2'd2;
   assign cs_push   = cs_valid_ff & ~cs_start_ff & sq_done & ~oq_full;

   hcc_divider u_div_x (
      .clock (clock), .reset (reset), .start (div_start), .ack (cs_load),
      .cls (job.cls_x), .num (job.mag_nx), .den (job.mag_d), .lim (lim_x),
      .idle (idle_x), .done (done_x), .quo (quo_x)
   );

   hcc_divider u_div_y (
      .clock (clock), .reset (reset), .start (div_start), .ack (cs_load),
      .cls (job.cls_y), .num (job.mag_ny), .den (job.mag_d), .lim (lim_y),
      .idle (idle_y), .done (done_y), .quo (quo_y)
   );

   hcc_sqrt u_sqrt (
      .clock (clock), .reset (reset), .start (cs_start_ff),
      .dx (cs_dx_ff), .dy (cs_dy_ff), .done (sq_done), .root (sq_root)
   );

   always_comb begin
      ref_x = COORD_W'(dj_px_ff) << COORD_FRAC_BITS;
      ref_y = COORD_W'(dj_py_ff) << COORD_FRAC_BITS;
      dx_in = (quo_x > ref_x) ? quo_x - ref_x : ref_x - quo_x;
      dy_in = (quo_y > ref_y) ? quo_y - ref_y : ref_y - quo_y;
      cs_valid_in = cs_valid_ff;
      if (cs_load) begin
         cs_valid_in = 1'b1;
      end else if (cs_push) begin
         cs_valid_in = 1'b0;
      end
   end

   always_comb begin
      first   = cs_corner_ff == CORNER_TL;
      last    = cs_corner_ff == CORNER_BR;
      ix      = cs_cx_ff[COORD_W-1:COORD_FRAC_BITS];
      iy      = cs_cy_ff[COORD_W-1:COORD_FRAC_BITS];
      minx_in = (first || ix < minx_ff) ? ix : minx_ff;
      miny_in = (first || iy < miny_ff) ? iy : miny_ff;
      maxx_in = (first || ix > maxx_ff) ? ix : maxx_ff;
      maxy_in = (first || iy > maxy_ff) ? iy : maxy_ff;
      dsum_in = (first ? '0 : dsum_ff) + DSUM_W'(sq_root);
      bl      = (pad_x < minx_in) ? pad_x : minx_in;
      bt      = (pad_y < miny_in) ? pad_y : miny_in;
      rx      = (right_x > maxx_in) ? right_x : maxx_in;
      by      = (bottom_y > maxy_in) ? bottom_y : maxy_in;
      rsp_in.corner_index = cs_corner_ff;
      rsp_in.corner_x     = cs_cx_ff;
      rsp_in.corner_y     = cs_cy_ff;
      rsp_in.last_corner  = last;
      rsp_in.box_left     = last ? bl : '0;
      rsp_in.box_top      = last ? bt : '0;
      rsp_in.box_width    = last ? rx - bl : '0;
      rsp_in.box_height   = last ? by - bt : '0;
      rsp_in.skip_frame   = last & (dsum_in > DSUM_W'(cfg.deviation_limit));
   end

   assign empty    = oq_cnt_ff == 2'd0;
   assign oq_pop   = pop & ~empty;
   assign rsp_data = oq_ff[rd_ptr_ff];

   always_comb begin
      oq_cnt_in = oq_cnt_ff;
      if (cs_push & ~oq_pop) begin
         oq_cnt_in = oq_cnt_ff + 2'd1;
      end else if (oq_pop & ~cs_push) begin
         oq_cnt_in = oq_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cs_valid_ff <= 1'b0;
         cs_start_ff <= 1'b0;
         wr_ptr_ff   <= 1'b0;
         rd_ptr_ff   <= 1'b0;
         oq_cnt_ff   <= 2'd0;
      end else begin
         cs_valid_ff <= cs_valid_in;
         cs_start_ff <= cs_load;
         oq_cnt_ff   <= oq_cnt_in;
         if (cs_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (oq_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_start) begin
         dj_corner_ff <= job.corner;
         dj_px_ff     <= job.px;
         dj_py_ff     <= job.py;
      end
      if (cs_load) begin
         cs_corner_ff <= dj_corner_ff;
         cs_cx_ff     <= quo_x;
         cs_cy_ff     <= quo_y;
         cs_dx_ff     <= dx_in;
         cs_dy_ff     <= dy_in;
      end
      if (cs_push) begin
         minx_ff <= minx_in;
         miny_ff <= miny_in;
         maxx_ff <= maxx_in;
         maxy_ff <= maxy_in;
         dsum_ff <= dsum_in;
         oq_ff[wr_ptr_ff] <= rsp_in;
      end
   end

endmodule

// ----- rtl/core/homography_corner_check.sv -----
// top level of the homography corner check
//
// Push one 3x3 homography (signed Q16.24 coefficients) and pop four
// transactions, one per padded frame corner in the order top-left,
// bottom-left, top-right, bottom-right; the fourth carries the bounding
// box and the skip flag. A new homography is taken as soon as the front
// end has issued the previous one's fourth corner into its pipeline, so
// items overlap. The pair of bit-serial dividers, which produce 21 quotient
// bits per corner plus load and hand-off, is the limiting unit. From push
// to the last result the path runs through the front stages, four
// divisions, then the square root of the last corner.
// Configuration registers are written through the csr port, which is
// always ready; write them only while no homography is in flight.
module homography_corner_check import hcc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // input transactions
   input  logic                  push,
   output logic                  full,
   input  req_type               req_data,
   // result transactions
   output logic                  empty,
   input  logic                  pop,
   output rsp_type               rsp_data,
   // configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    job_push, job_full, job_pop, job_empty;
   job_type job_wr, job_rd;

   // register file never stalls
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:     cfg_in.frame_width     = csr_data[11:0];
            CSR_FRAME_HEIGHT:    cfg_in.frame_height    = csr_data[11:0];
            CSR_PAD_LEFT:        cfg_in.pad_left        = csr_data[9:0];
            CSR_PAD_TOP:         cfg_in.pad_top         = csr_data[9:0];
            CSR_DEVIATION_LIMIT: cfg_in.deviation_limit = csr_data[23:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width     <= 12'd640;
         cfg_ff.frame_height    <= 12'd480;
         cfg_ff.pad_left        <= 10'd64;
         cfg_ff.pad_top         <= 10'd64;
         cfg_ff.deviation_limit <= 24'd6144;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: holds the homography, issues one corner a cycle into the queue unless the queue is full
   hcc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .job_full (job_full),
      .job_push (job_push),
      .job      (job_wr)
   );

   // decouples the front from the slow dividers
   hcc_job_queue u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_wr),
      .full      (job_full),
      .pop       (job_pop),
      .empty     (job_empty),
      .pop_data  (job_rd)
   );

   // back: divide, deviation, box, result queue
   hcc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_empty (job_empty),
      .job       (job_rd),
      .job_pop   (job_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule
